/* rtl/sprite_screen_projection_macros.svh */
// Assertion macros for the sprite screen projection block.
`ifndef SPRITE_SCREEN_PROJECTION_MACROS_SVH
`define SPRITE_SCREEN_PROJECTION_MACROS_SVH
`ifndef ASSERT_OFF
`define SSP_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
`define SSP_ASSERT_NEVER(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define SSP_ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define SSP_ASSERT_NEVER(name, clk, rst_n, cond)
`endif
`endif

/* rtl/ssp_pkg.sv */
// Shared constants, register codes and payload types of the sprite projection.
package ssp_pkg;
	localparam int FRAC_BITS  = 16;
	localparam int SCREEN_MAX = 4096;
	localparam int WORD_W     = 32;
	localparam int SCR_W      = 13;
	localparam int PROD_W     = 2 * WORD_W;
	localparam int DIV_W      = PROD_W - FRAC_BITS + 1;
	localparam int DIV_QB     = WORD_W + 1;
	localparam int DIV_NB     = DIV_W + FRAC_BITS;
	localparam int IDX_W      = 4;

	typedef enum logic [IDX_W-1:0] {
		REG_PLAYER_X      = 4'd0,
		REG_PLAYER_Y      = 4'd1,
		REG_DIR_X         = 4'd2,
		REG_DIR_Y         = 4'd3,
		REG_PLANE_X       = 4'd4,
		REG_PLANE_Y       = 4'd5,
		REG_SCREEN_WIDTH  = 4'd6,
		REG_SCREEN_HEIGHT = 4'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] sprite_x;
		logic signed [WORD_W-1:0] sprite_y;
	} sprite_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] depth;
		logic                     in_front;
		logic signed [15:0]       screen_col;
		logic        [15:0]       sprite_size;
		logic        [14:0]       first_col;
		logic signed [15:0]       last_col;
		logic        [11:0]       first_row;
		logic        [11:0]       last_row;
	} proj_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] player_x;
		logic signed [WORD_W-1:0] player_y;
		logic signed [WORD_W-1:0] dir_x;
		logic signed [WORD_W-1:0] dir_y;
		logic signed [WORD_W-1:0] plane_x;
		logic signed [WORD_W-1:0] plane_y;
		logic        [SCR_W-1:0]  screen_width;
		logic        [SCR_W-1:0]  screen_height;
	} cam_t;
endpackage

/* rtl/sprite_screen_projection.sv */
// Top level of the sprite screen projection pipeline.
// Use: write the camera (player position, direction, plane) and the screen size
// through the cfg channel while no sprite is in flight; cfg_ready is always high
// and writes to indexes past the screen height are dropped.
// Each request on the sprite channel carries one world position and yields
// exactly one request on the proj channel: depth, in_front flag, centre column,
// square size and clamped column and row bounds, in input order.
// The path runs through three front stages (offset, products, determinant and
// numerators), two 36-stage dividers in a row (camera-space x and depth, then
// the column ratio and the size quotient) and three back stages, the last
// being the output register.
// Throughput is one sprite per cycle unless proj_ready holds the pipeline;
// the dividers retire one quotient bit per stage so each stage holds one wide compare and subtract.
// When proj_ready is low with a result waiting, the whole pipeline holds and
// sprite_ready drops; nothing is lost or repeated.
// Reset clears all valid bits and loads the default camera and 640x480 screen.
`include "sprite_screen_projection_macros.svh"
module sprite_screen_projection (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        sprite_valid,
	output logic                        sprite_ready,
	input  ssp_pkg::sprite_t            sprite,
	output logic                        proj_valid,
	input  logic                        proj_ready,
	output ssp_pkg::proj_t              proj,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ssp_pkg::IDX_W-1:0]   cfg_index,
	input  logic [ssp_pkg::WORD_W-1:0]  cfg_data
);
	import ssp_pkg::*;

	cam_t                     cam;
	logic                     en;
	logic                     f_vld, a_vld, b_vld;
	logic signed [DIV_W-1:0]  det, nx, ny;
	logic signed [WORD_W-1:0] tx, ty, ratio, size_q;
	logic [WORD_W-1:0]        ty_tag;

	assign en           = !proj_valid || proj_ready;
	assign sprite_ready = en;

	ssp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cam       (cam)
	);

	ssp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_i    (sprite_valid),
		.sprite_i (sprite),
		.cam      (cam),
		.vld_o    (f_vld),
		.det_o    (det),
		.nx_o     (nx),
		.ny_o     (ny)
	);

	ssp_div u_div_tx (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (f_vld),
		.num_i  (nx),
		.den_i  (det),
		.tag_i  ('0),
		.vld_o  (a_vld),
		.quo_o  (tx),
		.tag_o  ()
	);

	ssp_div u_div_ty (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (f_vld),
		.num_i  (ny),
		.den_i  (det),
		.tag_i  ('0),
		.vld_o  (),
		.quo_o  (ty),
		.tag_o  ()
	);

	ssp_div u_div_ratio (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (a_vld),
		.num_i  (DIV_W'(tx)),
		.den_i  (DIV_W'(ty)),
		.tag_i  (ty),
		.vld_o  (b_vld),
		.quo_o  (ratio),
		.tag_o  (ty_tag)
	);

	ssp_div u_div_size (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (a_vld),
		.num_i  ($signed(DIV_W'(cam.screen_height))),
		.den_i  (DIV_W'(ty)),
		.tag_i  ('0),
		.vld_o  (),
		.quo_o  (size_q),
		.tag_o  ()
	);

	ssp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_i   (b_vld),
		.ratio_i (ratio),
		.size_i  (size_q),
		.ty_i    ($signed(ty_tag)),
		.cam     (cam),
		.vld_o   (proj_valid),
		.proj_o  (proj)
	);

	`SSP_ASSERT_IMPLY(a_front_depth, clk, arst_n, proj_valid && proj.in_front, $signed(proj.depth) > 0)
	`SSP_ASSERT_IMPLY(a_zero_depth_size, clk, arst_n, proj_valid && proj.depth == '0, proj.sprite_size == 16'hFFFF)
	`SSP_ASSERT_IMPLY(a_row_bound, clk, arst_n, proj_valid, proj.last_row < cam.screen_height)
	`SSP_ASSERT_NEVER(a_first_row, clk, arst_n, proj_valid && proj.first_row > 12'd2048)
endmodule

/* rtl/ssp_cfg.sv */
// Camera and screen configuration registers.
module ssp_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ssp_pkg::IDX_W-1:0]   cfg_index,
	input  logic [ssp_pkg::WORD_W-1:0]  cfg_data,
	output ssp_pkg::cam_t               cam
);
	import ssp_pkg::*;

	logic [SCR_W-1:0] scr_clamped;
	cam_t             cam_q;

	always_comb begin
		scr_clamped = cfg_data[SCR_W-1:0];
		if (scr_clamped == '0)
			scr_clamped = SCR_W'(1);
		else if (scr_clamped > SCR_W'(SCREEN_MAX))
			scr_clamped = SCR_W'(SCREEN_MAX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_q.player_x      <= '0;
			cam_q.player_y      <= '0;
			cam_q.dir_x         <= WORD_W'(65536);
			cam_q.dir_y         <= '0;
			cam_q.plane_x       <= '0;
			cam_q.plane_y       <= WORD_W'(43254);
			cam_q.screen_width  <= SCR_W'(640);
			cam_q.screen_height <= SCR_W'(480);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PLAYER_X:      cam_q.player_x      <= cfg_data;
				REG_PLAYER_Y:      cam_q.player_y      <= cfg_data;
				REG_DIR_X:         cam_q.dir_x         <= cfg_data;
				REG_DIR_Y:         cam_q.dir_y         <= cfg_data;
				REG_PLANE_X:       cam_q.plane_x       <= cfg_data;
				REG_PLANE_Y:       cam_q.plane_y       <= cfg_data;
				REG_SCREEN_WIDTH:  cam_q.screen_width  <= scr_clamped;
				REG_SCREEN_HEIGHT: cam_q.screen_height <= scr_clamped;
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign cam       = cam_q;
endmodule

/* rtl/ssp_front.sv */
// Front stages: offset from player, camera products, determinant and numerators.
module ssp_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              vld_i,
	input  ssp_pkg::sprite_t                  sprite_i,
	input  ssp_pkg::cam_t                     cam,
	output logic                              vld_o,
	output logic signed [ssp_pkg::DIV_W-1:0]  det_o,
	output logic signed [ssp_pkg::DIV_W-1:0]  nx_o,
	output logic signed [ssp_pkg::DIV_W-1:0]  ny_o
);
	import ssp_pkg::*;

	localparam int SW = PROD_W - FRAC_BITS;

	function automatic logic signed [WORD_W-1:0] sub_sat(
		input logic signed [WORD_W-1:0] a,
		input logic signed [WORD_W-1:0] b
	);
		logic signed [WORD_W:0] d;
		d = (WORD_W+1)'(a) - (WORD_W+1)'(b);
		if (d[WORD_W] != d[WORD_W-1])
			return d[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
		return d[WORD_W-1:0];
	endfunction

	logic                     vld_s1, vld_s2, vld_s3;
	logic signed [WORD_W-1:0] rx_s1, ry_s1;
	logic signed [PROD_W-1:0] deta_s2, detb_s2, nxa_s2, nxb_s2, nya_s2, nyb_s2;
	logic signed [DIV_W-1:0]  det_s3, nx_s3, ny_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s1   <= sub_sat(sprite_i.sprite_x, cam.player_x);
			ry_s1   <= sub_sat(sprite_i.sprite_y, cam.player_y);
			deta_s2 <= cam.plane_x * cam.dir_y;
			detb_s2 <= cam.dir_x * cam.plane_y;
			nxa_s2  <= cam.dir_y * rx_s1;
			nxb_s2  <= cam.dir_x * ry_s1;
			nya_s2  <= cam.plane_x * ry_s1;
			nyb_s2  <= cam.plane_y * rx_s1;
			det_s3  <= DIV_W'($signed(deta_s2[PROD_W-1:FRAC_BITS]))
				- DIV_W'($signed(detb_s2[PROD_W-1:FRAC_BITS]));
			nx_s3   <= DIV_W'($signed(nxa_s2[PROD_W-1:FRAC_BITS]))
				- DIV_W'($signed(nxb_s2[PROD_W-1:FRAC_BITS]));
			ny_s3   <= DIV_W'($signed(nya_s2[PROD_W-1:FRAC_BITS]))
				- DIV_W'($signed(nyb_s2[PROD_W-1:FRAC_BITS]));
		end
	end

	assign vld_o = vld_s3;
	assign det_o = det_s3;
	assign nx_o  = nx_s3;
	assign ny_o  = ny_s3;
endmodule

/* rtl/ssp_div.sv */
// Pipelined restoring divider: num * 2^FRAC_BITS / den, truncated and saturated.
module ssp_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               vld_i,
	input  logic signed [ssp_pkg::DIV_W-1:0]   num_i,
	input  logic signed [ssp_pkg::DIV_W-1:0]   den_i,
	input  logic        [ssp_pkg::WORD_W-1:0]  tag_i,
	output logic                               vld_o,
	output logic signed [ssp_pkg::WORD_W-1:0]  quo_o,
	output logic        [ssp_pkg::WORD_W-1:0]  tag_o
);
	import ssp_pkg::*;

	localparam logic [DIV_QB-1:0] POS_LIM = {2'b00, {(WORD_W-1){1'b1}}};
	localparam logic [DIV_QB-1:0] NEG_LIM = {2'b01, {(WORD_W-1){1'b0}}};

	// operand magnitudes
	logic              vld_s1, neg_s1, nz_s1;
	logic [DIV_W-1:0]  an_s1, ad_s1;
	logic [WORD_W-1:0] tag_s1;
	logic [DIV_NB-1:0] nn;

	// iteration stages
	logic              vld_s [0:DIV_QB];
	logic              neg_s [0:DIV_QB];
	logic              nz_s  [0:DIV_QB];
	logic              ovf_s [0:DIV_QB];
	logic [DIV_W-1:0]  rem_s [0:DIV_QB];
	logic [DIV_W-1:0]  den_s [0:DIV_QB];
	logic [DIV_QB-1:0] low_s [0:DIV_QB];
	logic [DIV_QB-1:0] q_s   [0:DIV_QB];
	logic [WORD_W-1:0] tag_s [0:DIV_QB];

	// result
	logic                     vld_sf;
	logic signed [WORD_W-1:0] quo_sf;
	logic [WORD_W-1:0]        tag_sf;
	logic                     over;
	logic [DIV_QB-1:0]        qneg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s1   <= vld_i;
			vld_s[0] <= vld_s1;
		end
	end

	assign nn = {an_s1, {FRAC_BITS{1'b0}}};

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1   <= num_i[DIV_W-1] ^ den_i[DIV_W-1];
			nz_s1    <= (num_i == '0);
			an_s1    <= num_i[DIV_W-1] ? DIV_W'(-num_i) : DIV_W'(num_i);
			ad_s1    <= den_i[DIV_W-1] ? DIV_W'(-den_i) : DIV_W'(den_i);
			tag_s1   <= tag_i;
			neg_s[0] <= neg_s1;
			nz_s[0]  <= nz_s1;
			ovf_s[0] <= DIV_W'(nn[DIV_NB-1:DIV_QB]) >= ad_s1;
			rem_s[0] <= DIV_W'(nn[DIV_NB-1:DIV_QB]);
			den_s[0] <= ad_s1;
			low_s[0] <= nn[DIV_QB-1:0];
			q_s[0]   <= '0;
			tag_s[0] <= tag_s1;
		end
	end

	for (genvar k = 0; k < DIV_QB; k++) begin : g_step
		logic [DIV_W:0] trial;
		logic           ge;

		assign trial = {rem_s[k], low_s[k][DIV_QB-1]};
		assign ge    = trial >= {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else if (en)
				vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? DIV_W'(trial - {1'b0, den_s[k]}) : trial[DIV_W-1:0];
				low_s[k+1] <= {low_s[k][DIV_QB-2:0], 1'b0};
				q_s[k+1]   <= {q_s[k][DIV_QB-2:0], ge};
				den_s[k+1] <= den_s[k];
				neg_s[k+1] <= neg_s[k];
				nz_s[k+1]  <= nz_s[k];
				ovf_s[k+1] <= ovf_s[k];
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	assign over = ovf_s[DIV_QB]
		|| (neg_s[DIV_QB] ? (q_s[DIV_QB] > NEG_LIM) : (q_s[DIV_QB] > POS_LIM));
	assign qneg = -q_s[DIV_QB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_sf <= 1'b0;
		else if (en)
			vld_sf <= vld_s[DIV_QB];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_sf <= tag_s[DIV_QB];
			if (nz_s[DIV_QB])
				quo_sf <= '0;
			else if (over)
				quo_sf <= neg_s[DIV_QB] ? NEG_LIM[WORD_W-1:0] : POS_LIM[WORD_W-1:0];
			else
				quo_sf <= neg_s[DIV_QB] ? qneg[WORD_W-1:0] : q_s[DIV_QB][WORD_W-1:0];
		end
	end

	assign vld_o = vld_sf;
	assign quo_o = quo_sf;
	assign tag_o = tag_sf;
endmodule

/* rtl/ssp_back.sv */
// Back stages: screen column, on-screen size and clamped bounds.
module ssp_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               vld_i,
	input  logic signed [ssp_pkg::WORD_W-1:0]  ratio_i,
	input  logic signed [ssp_pkg::WORD_W-1:0]  size_i,
	input  logic signed [ssp_pkg::WORD_W-1:0]  ty_i,
	input  ssp_pkg::cam_t                      cam,
	output logic                               vld_o,
	output ssp_pkg::proj_t                     proj_o
);
	import ssp_pkg::*;

	localparam int PW  = SCR_W + WORD_W + 2;
	localparam int BW  = 19;
	localparam int ONE = 1 << FRAC_BITS;
	localparam logic signed [PW-1:0] COL_HI = PW'(32767);
	localparam logic signed [PW-1:0] COL_LO = -PW'(32768);
	localparam logic [WORD_W:0]      DIM_MAX = (WORD_W+1)'(65535);

	function automatic logic signed [BW-1:0] half_tz(input logic signed [BW-1:0] v);
		logic signed [BW-1:0] t;
		t = v + BW'(v[BW-1]);
		return t >>> 1;
	endfunction

	logic [SCR_W-2:0]         half_w;
	logic signed [WORD_W+1:0] gain;
	logic [WORD_W:0]          mag;
	logic signed [PW-1:0]     adj, shifted;
	logic [SCR_W-1:0]         hh2;
	logic signed [BW-1:0]     col2, fr_v, lr_v, fc_v, lc_v;

	logic                     vld_s1, vld_s2, vld_s3;
	logic signed [PW-1:0]     prod_s1;
	logic [15:0]              dim_s1, dim_s2;
	logic signed [WORD_W-1:0] ty_s1, ty_s2;
	logic signed [15:0]       col_s2;
	proj_t                    proj_s3;

	assign half_w = cam.screen_width[SCR_W-1:1];
	assign gain   = (WORD_W+2)'(ratio_i) + (WORD_W+2)'(ONE);
	assign mag    = size_i[WORD_W-1] ? (WORD_W+1)'(-(WORD_W+1)'(size_i))
		: (WORD_W+1)'(size_i);

	assign adj     = prod_s1 + (prod_s1[PW-1] ? PW'(ONE - 1) : '0);
	assign shifted = adj >>> FRAC_BITS;

	assign hh2  = {cam.screen_height[SCR_W-1:1], 1'b0};
	assign col2 = BW'(col_s2) <<< 1;
	assign fr_v = half_tz($signed(BW'(hh2)) - $signed(BW'(dim_s2)));
	assign lr_v = half_tz($signed(BW'(hh2)) + $signed(BW'(dim_s2)));
	assign fc_v = half_tz(col2 - $signed(BW'(dim_s2)));
	assign lc_v = half_tz(col2 + $signed(BW'(dim_s2)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= $signed({1'b0, half_w}) * gain;
			dim_s1  <= (mag > DIM_MAX) ? 16'hFFFF : mag[15:0];
			ty_s1   <= ty_i;

			dim_s2 <= dim_s1;
			ty_s2  <= ty_s1;
			if (shifted > COL_HI)
				col_s2 <= 16'sh7FFF;
			else if (shifted < COL_LO)
				col_s2 <= 16'sh8000;
			else
				col_s2 <= shifted[15:0];

			proj_s3.depth       <= ty_s2;
			proj_s3.in_front    <= (ty_s2 > 0);
			proj_s3.screen_col  <= col_s2;
			proj_s3.sprite_size <= dim_s2;
			proj_s3.first_row   <= fr_v[BW-1] ? '0 : fr_v[11:0];
			proj_s3.last_row    <= (lr_v >= $signed(BW'(cam.screen_height)))
				? 12'(cam.screen_height - SCR_W'(1)) : lr_v[11:0];
			proj_s3.first_col   <= fc_v[BW-1] ? '0 : fc_v[14:0];
			proj_s3.last_col    <= (lc_v >= $signed(BW'(cam.screen_width)))
				? 16'(cam.screen_width - SCR_W'(1)) : lc_v[15:0];
		end
	end

	assign vld_o  = vld_s3;
	assign proj_o = proj_s3;
endmodule
